### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define LPHT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after a trigger.
`define LPHT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and fixed field widths of the linear probing hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 7;
  localparam int AGE_W    = 16;
  localparam int RES_W    = 2;
  localparam int IDX_W    = 4;
  // (h + c) * c stays below 2**16 for h < 256 and c < 128
  localparam int PROD_W   = 16;
  localparam int SUM_W    = 9;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_st_t;

  typedef enum logic [RES_W-1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2,
    RES_LONG = 2'd3
  } res_t;

endpackage

`default_nettype wire

### rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_in_if / lpht_out_if
// Valid/ready channels for key characters and for results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpht_in_if;
  import lpht_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] key_char;
  logic              key_last;
  logic [AGE_W-1:0]  age_value;

  modport source (output valid, opcode, key_char, key_last, age_value, input ready);
  modport sink   (input valid, opcode, key_char, key_last, age_value, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] status;
  logic [IDX_W-1:0] slot_index;
  logic [AGE_W-1:0] age_out;

  modport source (output valid, status, slot_index, age_out, input ready);
  modport sink   (input valid, status, slot_index, age_out, output ready);
endinterface

`default_nettype wire

### rtl/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash
// Running hash step h' = ((h + c) * c) mod SLOTS, reduced by a reciprocal
// multiply: product, quotient and remainder each take one registered stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_hash #(
  parameter int SLOTS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [lpht_pkg::CHAR_W-1:0]        c_in,
  input  wire logic [$clog2(SLOTS)-1:0]           h_in,
  output logic                                    done,
  output logic [$clog2(SLOTS)-1:0]                h_out
);
  import lpht_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  // floor(x / SLOTS) == (x * RCP) >> RSH for every x below 2**PROD_W
  localparam int RSH   = PROD_W + SW;
  localparam int RCP_W = PROD_W + 1;
  localparam int QW    = PROD_W + RCP_W;
  localparam int RCP   = ((1 << RSH) + SLOTS - 1) / SLOTS;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] q_r;
  logic [SW-1:0]     h_r;
  logic              v1_r;
  logic              v2_r;
  logic              done_r;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod_w;
  logic [QW-1:0]     qp;
  logic [PROD_W-1:0] q_w;
  logic [PROD_W-1:0] rem_w;

  // start value of the reduction
  assign sum    = SUM_W'(h_in) + SUM_W'(c_in);
  assign prod_w = PROD_W'(sum) * PROD_W'(c_in);

  // quotient by reciprocal, then remainder
  assign qp    = QW'(prod_r) * QW'(RCP);
  assign q_w   = PROD_W'(qp >> RSH);
  assign rem_w = prod_r - PROD_W'(q_r * PROD_W'(SLOTS));

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_w;
    end
    if (v1_r) begin
      q_r <= q_w;
    end
    if (v2_r) begin
      h_r <= rem_w[SW-1:0];
    end
  end

  assign done  = done_r;
  assign h_out = h_r;

endmodule

`default_nettype wire

### rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and deleted markers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one key character per item; key_last marks the final one,
//   which also carries opcode (insert, lookup, delete) and age_value.
//   out_ch gives one result item per key: status, slot_index, age_out.
// Sequence: a character is accepted in ST_IDLE; ST_MOD then waits for
//   the hash unit (product, quotient, remainder), taking no new character.
//   The final character walks the slots: ST_FIND per slot skipped, then
//   ST_FIND_META to read a stored length, ST_CMP_RD and ST_CMP_CHK per
//   character compared, as key buffer and name memory have one registered
//   read port each. Insert copies each character via ST_COPY_RD, ST_COPY_WR.
// Stalls: ST_RESP loads a finished result into the output register, where it
//   waits; characters of the next key are still taken, but after the next
//   final character ST_RESP waits until the previous result has been taken.
// Reset: slot states clear at once (all empty), key length and hash clear.
//   Name, length and age memories hold stale data until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module linear_probe_hash_table #(
  parameter int SLOTS      = 16,
  parameter int NAME_BYTES = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpht_in_if.sink     in_ch,
  lpht_out_if.source  out_ch
);
  import lpht_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int JW = $clog2(NAME_BYTES);
  localparam int LW = $clog2(NAME_BYTES + 2);
  localparam int NM_DEPTH = SLOTS * (2 ** JW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_INS_SCAN, ST_COPY_RD, ST_COPY_WR,
    ST_FIND, ST_FIND_META, ST_CMP_RD, ST_CMP_CHK, ST_RESP
  } state_t;

  state_t             state_r;
  logic [LW-1:0]      klen_r;
  logic [SW-1:0]      hash_r;
  logic [SW-1:0]      s_r;
  logic [SW-1:0]      cnt_r;
  logic [LW-1:0]      j_r;
  logic [OP_W-1:0]    op_r;
  logic               last_r;
  logic [AGE_W-1:0]   age_in_r;
  res_t               res_st_r;
  logic [IDX_W-1:0]   res_slot_r;
  logic [AGE_W-1:0]   res_age_r;
  logic               out_valid_r;
  logic [RES_W-1:0]   out_status_r;
  logic [IDX_W-1:0]   out_slot_r;
  logic [AGE_W-1:0]   out_age_r;
  slot_st_t           slot_st_r [SLOTS];

  // memories
  logic [CHAR_W-1:0]  kb_mem  [NAME_BYTES];
  logic [CHAR_W-1:0]  nm_mem  [NM_DEPTH];
  logic [LW-1:0]      len_mem [SLOTS];
  logic [AGE_W-1:0]   age_mem [SLOTS];
  logic [CHAR_W-1:0]  kb_q;
  logic [CHAR_W-1:0]  nm_q;
  logic [LW-1:0]      len_q;
  logic [AGE_W-1:0]   age_q;

  logic               accept;
  logic               kb_we;
  logic               nm_we;
  logic               meta_we;
  logic               hdone;
  logic [SW-1:0]      h_out;
  logic [SW-1:0]      s_inc;
  logic               probe_end;
  logic               j_end;
  logic [SW+IDX_W-1:0] s_ext;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign s_inc     = (s_r == SW'(SLOTS - 1)) ? '0 : s_r + 1'b1;
  assign probe_end = (cnt_r == SW'(SLOTS - 1));
  assign j_end     = ((j_r + 1'b1) == klen_r);
  assign s_ext     = {{IDX_W{1'b0}}, s_r};

  // memory write enables
  assign kb_we   = accept && (klen_r < LW'(NAME_BYTES));
  assign nm_we   = (state_r == ST_COPY_WR);
  assign meta_we = (state_r == ST_INS_SCAN) && (slot_st_r[s_r] != SLOT_USED);

  lpht_hash #(.SLOTS(SLOTS)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .c_in  (in_ch.key_char),
    .h_in  (hash_r),
    .done  (hdone),
    .h_out (h_out)
  );

  // key buffer
  always_ff @(posedge clk) begin
    if (kb_we) begin
      kb_mem[klen_r[JW-1:0]] <= in_ch.key_char;
    end
    kb_q <= kb_mem[j_r[JW-1:0]];
  end

  // stored names
  always_ff @(posedge clk) begin
    if (nm_we) begin
      nm_mem[{s_r, j_r[JW-1:0]}] <= kb_q;
    end
    nm_q <= nm_mem[{s_r, j_r[JW-1:0]}];
  end

  // stored lengths and ages
  always_ff @(posedge clk) begin
    if (meta_we) begin
      len_mem[s_r] <= klen_r;
      age_mem[s_r] <= age_in_r;
    end
    len_q <= len_mem[s_r];
    age_q <= age_mem[s_r];
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      klen_r      <= '0;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_st_r[i] <= SLOT_EMPTY;
      end
    end else begin
      // drain, unless a new result is loaded below
      if (out_valid_r && out_ch.ready && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= in_ch.opcode;
            last_r   <= in_ch.key_last;
            age_in_r <= in_ch.age_value;
            klen_r   <= (klen_r < LW'(NAME_BYTES)) ? klen_r + 1'b1
                                                   : LW'(NAME_BYTES + 1);
            state_r  <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (hdone) begin
            hash_r <= h_out;
            s_r    <= h_out;
            cnt_r  <= '0;
            j_r    <= '0;
            res_slot_r <= '0;
            res_age_r  <= '0;
            if (!last_r) begin
              state_r <= ST_IDLE;
            end else if (klen_r > LW'(NAME_BYTES)) begin
              res_st_r <= RES_LONG;
              state_r  <= ST_RESP;
            end else begin
              case (op_r)
                OP_INSERT: state_r <= ST_INS_SCAN;
                OP_LOOKUP, OP_DELETE: state_r <= ST_FIND;
                default: begin
                  res_st_r <= RES_MISS;
                  state_r  <= ST_RESP;
                end
              endcase
            end
          end
        end
        ST_INS_SCAN: begin
          if (slot_st_r[s_r] != SLOT_USED) begin
            slot_st_r[s_r] <= SLOT_USED;
            state_r        <= ST_COPY_RD;
          end else if (probe_end) begin
            res_st_r <= RES_FULL;
            state_r  <= ST_RESP;
          end else begin
            s_r   <= s_inc;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_COPY_RD: state_r <= ST_COPY_WR;
        ST_COPY_WR: begin
          if (j_end) begin
            res_st_r   <= RES_OK;
            res_slot_r <= s_ext[IDX_W-1:0];
            state_r    <= ST_RESP;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_COPY_RD;
          end
        end
        ST_FIND: begin
          if (slot_st_r[s_r] == SLOT_EMPTY) begin
            res_st_r <= RES_MISS;
            state_r  <= ST_RESP;
          end else if (slot_st_r[s_r] == SLOT_USED) begin
            state_r <= ST_FIND_META;
          end else if (probe_end) begin
            res_st_r <= RES_MISS;
            state_r  <= ST_RESP;
          end else begin
            s_r   <= s_inc;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_FIND_META, ST_CMP_CHK: begin
          // a mismatch moves on to the next slot, or misses after the last probe
          if ((state_r == ST_FIND_META && len_q == klen_r) ||
              (state_r == ST_CMP_CHK && kb_q == nm_q && !j_end)) begin
            if (state_r == ST_CMP_CHK) begin
              j_r <= j_r + 1'b1;
            end
            state_r <= ST_CMP_RD;
          end else if (state_r == ST_CMP_CHK && kb_q == nm_q) begin
            res_st_r   <= RES_OK;
            res_slot_r <= s_ext[IDX_W-1:0];
            res_age_r  <= age_q;
            if (op_r == OP_DELETE) begin
              slot_st_r[s_r] <= SLOT_DELETED;
            end
            state_r <= ST_RESP;
          end else if (probe_end) begin
            res_st_r <= RES_MISS;
            state_r  <= ST_RESP;
          end else begin
            s_r     <= s_inc;
            cnt_r   <= cnt_r + 1'b1;
            j_r     <= '0;
            state_r <= ST_FIND;
          end
        end
        ST_CMP_RD: state_r <= ST_CMP_CHK;
        ST_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_st_r;
            out_slot_r   <= res_slot_r;
            out_age_r    <= res_age_r;
            klen_r       <= '0;
            hash_r       <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_index = out_slot_r;
  assign out_ch.age_out    = out_age_r;

  // checks
  `LPHT_ASSERT(a_hdone_in_mod, !hdone || state_r == ST_MOD)
  `LPHT_ASSERT(a_klen_bound, klen_r <= LW'(NAME_BYTES + 1))
  `LPHT_ASSERT(a_cmp_in_key, state_r != ST_CMP_CHK || j_r < klen_r)
  `LPHT_ASSERT_NEXT(a_out_drain, out_valid_r && out_ch.ready && state_r != ST_RESP,
                    !out_valid_r)

endmodule

`default_nettype wire

### test/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Streams keys into the hash table and checks every result against a
// behavioral table model kept in the bench, with random idling and a long
// receiver hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int SLOTS      = 16;
  localparam int NAME_BYTES = 256;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] key_char;
    logic              key_last;
    logic [AGE_W-1:0]  age_value;
  } char_item_t;

  typedef struct packed {
    logic [RES_W-1:0] status;
    logic [IDX_W-1:0] slot_index;
    logic [AGE_W-1:0] age_out;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  lpht_in_if  in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #10 clk = ~clk;

  // Bench copy of the table
  slot_st_t          tbl_state [SLOTS];
  logic [CHAR_W-1:0] tbl_name  [SLOTS][$];
  logic [AGE_W-1:0]  tbl_age   [SLOTS];
  logic [CHAR_W-1:0] cur_key   [$];
  int                cur_len;
  int                cur_hash;

  char_item_t pending_chars [$];
  result_t    expected_results [$];
  int         fail_count = 0;
  bit         stim_done = 1'b0;
  bit         hold_out = 1'b0;
  bit         calm = 1'b0;
  bit         in_acc_r = 1'b0;

  // Names stored by the stimulus, for hits on lookup and delete
  logic [CHAR_W-1:0] known_names [$][$];

  function automatic bit names_equal(int s);
    if (tbl_name[s].size() != cur_key.size()) return 1'b0;
    foreach (cur_key[i]) if (tbl_name[s][i] !== cur_key[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the table model by one accepted character
  function automatic void table_step(char_item_t it);
    result_t r;
    int s;
    bit hit;
    if (cur_len < NAME_BYTES) begin
      cur_key.push_back(it.key_char);
      cur_len++;
    end else begin
      cur_len = NAME_BYTES + 1;
    end
    cur_hash = ((cur_hash + it.key_char) * it.key_char) % SLOTS;
    if (!it.key_last) return;
    r = '{status: RES_MISS, slot_index: '0, age_out: '0};
    if (cur_len > NAME_BYTES) begin
      r.status = RES_LONG;
    end else if (it.opcode == OP_INSERT) begin
      r.status = RES_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        s = (cur_hash + i) % SLOTS;
        if (tbl_state[s] != SLOT_USED) begin
          tbl_state[s] = SLOT_USED;
          tbl_name[s] = cur_key;
          tbl_age[s] = it.age_value;
          r.status = RES_OK;
          r.slot_index = IDX_W'(s);
          break;
        end
      end
    end else if (it.opcode == OP_LOOKUP || it.opcode == OP_DELETE) begin
      hit = 1'b0;
      for (int i = 0; i < SLOTS && !hit; i++) begin
        s = (cur_hash + i) % SLOTS;
        if (tbl_state[s] == SLOT_EMPTY) break;
        if (tbl_state[s] == SLOT_USED && names_equal(s)) hit = 1'b1;
      end
      if (hit) begin
        r.status = RES_OK;
        r.slot_index = IDX_W'(s);
        r.age_out = tbl_age[s];
        if (it.opcode == OP_DELETE) tbl_state[s] = SLOT_DELETED;
      end
    end
    expected_results.push_back(r);
    cur_key.delete();
    cur_len = 0;
    cur_hash = 0;
  endfunction

  // Queue one key; opcode and age ride on the final character
  task automatic queue_key(logic [CHAR_W-1:0] name [$], logic [OP_W-1:0] op,
                           logic [AGE_W-1:0] age);
    char_item_t it;
    foreach (name[i]) begin
      it.key_char = name[i];
      it.key_last = (i == name.size() - 1);
      it.opcode = it.key_last ? op : OP_W'($urandom_range(0, 3));
      it.age_value = it.key_last ? age : AGE_W'($urandom);
      pending_chars.push_back(it);
    end
  endtask

  function automatic void random_name(output logic [CHAR_W-1:0] name [$], input int len);
    name.delete();
    for (int i = 0; i < len; i++) name.push_back(CHAR_W'($urandom_range(0, 127)));
  endfunction

  // Input acceptance seen at the rising edge
  always @(posedge clk) begin
    in_acc_r <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: presents the head of the queue, changes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_acc_r) begin
      // hold the offered item
    end else begin
      if (in_acc_r) void'(pending_chars.pop_front());
      if (pending_chars.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= pending_chars[0].opcode;
        in_ch.key_char  <= pending_chars[0].key_char;
        in_ch.key_last  <= pending_chars[0].key_last;
        in_ch.age_value <= pending_chars[0].age_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with a long hold-off counted here
  int hold_count = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_out && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  // Monitor: model accepted characters and check results at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        table_step('{opcode: in_ch.opcode, key_char: in_ch.key_char,
                     key_last: in_ch.key_last, age_value: in_ch.age_value});
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation: status %0d", out_ch.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index,
                   out_ch.slot_index);
            fail_count++;
          end
          if (out_ch.age_out !== want.age_out) begin
            $error("age_out: expected %0d, got %0d", want.age_out, out_ch.age_out);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [CHAR_W-1:0] nm [$];
    int len, pick, op;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.key_char = '0;
    in_ch.key_last = 1'b0;
    in_ch.age_value = '0;
    out_ch.ready = 1'b0;
    foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
    cur_len = 0;
    cur_hash = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: misses on empty table, extremes, zero char, unused opcode
    nm = '{7'd0};            queue_key(nm, OP_LOOKUP, 16'hFFFF);
    nm = '{7'd0};            queue_key(nm, OP_INSERT, 16'hFFFF);
    nm = '{7'd127};          queue_key(nm, OP_INSERT, 16'h0000);
    nm = '{7'd0};            queue_key(nm, OP_LOOKUP, 16'h1234);
    nm = '{7'd127, 7'd0};    queue_key(nm, OP_LOOKUP, 16'h0);
    nm = '{7'd127};          queue_key(nm, OP_W'(3), 16'hAAAA);
    nm = '{7'd127};          queue_key(nm, OP_DELETE, 16'h5555);
    nm = '{7'd127};          queue_key(nm, OP_DELETE, 16'h5555);
    nm = '{7'd127};          queue_key(nm, OP_LOOKUP, 16'h0);
    nm = '{7'd0};            queue_key(nm, OP_LOOKUP, 16'h0);
    // Key too long, then a maximum-length key
    random_name(nm, NAME_BYTES + 1); queue_key(nm, OP_INSERT, 16'h7);
    random_name(nm, NAME_BYTES);     queue_key(nm, OP_INSERT, 16'h8);
    // Fill the table, overflow it, then clear through tombstones
    for (int i = 0; i < SLOTS + 1; i++) begin
      nm = '{CHAR_W'(i + 1), 7'd5}; queue_key(nm, OP_INSERT, AGE_W'(i));
    end
    for (int i = 0; i < SLOTS; i++) begin
      nm = '{CHAR_W'(i + 1), 7'd5}; queue_key(nm, OP_DELETE, 16'h0);
    end
    nm = '{7'd0}; queue_key(nm, OP_DELETE, 16'h0);
    nm = '{7'd127}; queue_key(nm, OP_DELETE, 16'h0);

    // Receiver holds off while the sender keeps going
    hold_out = 1'b1;
    calm = 1'b1;
    for (int i = 0; i < 20; i++) begin
      random_name(nm, $urandom_range(1, 3)); queue_key(nm, OP_LOOKUP, 16'h0);
    end
    wait (hold_count >= HOLD_CYCLES);
    wait (pending_chars.size() == 0 && expected_results.size() == 0);
    calm = 1'b0;

    // Random: mostly operations on known short names
    for (int n = 0; n < 110; n++) begin
      if (n >= 40 && n < 60) calm = 1'b1; else calm = 1'b0;
      pick = $urandom_range(0, 99);
      if (known_names.size() > 0 && pick < 55) begin
        nm = known_names[$urandom_range(0, known_names.size() - 1)];
      end else begin
        len = $urandom_range(1, 3);
        random_name(nm, len);
        if (known_names.size() < 24) known_names.push_back(nm);
      end
      op = $urandom_range(0, 9);
      queue_key(nm, (op < 4) ? OP_INSERT : (op < 7) ? OP_LOOKUP :
                    (op < 9) ? OP_DELETE : OP_W'(3), AGE_W'($urandom));
      while (pending_chars.size() > 40) @(posedge clk);
    end
    calm = 1'b0;
    wait (pending_chars.size() == 0);
    stim_done = 1'b1;
  end

  // Finish once everything is drained
  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS linear_probe_hash_table");
    end else begin
      $display("FAIL linear_probe_hash_table");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("FAIL linear_probe_hash_table");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_if.sv
rtl/lpht_hash.sv
rtl/linear_probe_hash_table.sv
test/tb_linear_probe_hash_table.sv
